[sv/complex3x3_matrix_unit_macros.svh]
// assertion macros used by the matrix unit back end
// expects i_clk and i_rst_n in the scope of each use
`ifndef COMPLEX3X3_MATRIX_UNIT_MACROS_SVH
`define COMPLEX3X3_MATRIX_UNIT_MACROS_SVH

// same-cycle implication
`define CMU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CMU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cmu_pkg.sv]
// types, constants and term decoder for the 3x3 complex matrix unit
// no dependencies
package cmu_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 24;
    localparam int TRUNC_BITS  = 2 * WORD_BITS - FRAC_BITS;
    localparam int SPLIT_BITS  = 16;
    localparam int PROD3_BITS  = WORD_BITS + TRUNC_BITS;
    localparam int ACC_BITS    = 56;
    localparam int IDX_BITS    = 5;
    localparam int NUM_WORDS   = 18;
    localparam int A_DEPTH     = 2 * NUM_WORDS;
    localparam int A_AW        = $clog2(A_DEPTH);
    localparam int QDEPTH      = 2;

    localparam logic [2:0] OP_LOAD_A = 3'd0;
    localparam logic [2:0] OP_LOAD_B = 3'd1;
    localparam logic [2:0] OP_MUL    = 3'd2;
    localparam logic [2:0] OP_CONJ   = 3'd3;
    localparam logic [2:0] OP_ADJ    = 3'd4;
    localparam logic [2:0] OP_DET    = 3'd5;

    typedef struct packed {
        logic [2:0]          opcode;
        logic [4:0]          word_index;
        logic signed [31:0]  word_value;
    } t_in_item;

    typedef struct packed {
        logic [4:0]          result_index;
        logic signed [31:0]  result_value;
        logic                last_word;
        logic                overflow;
    } t_out_item;

    typedef enum logic [1:0] {CK_LOAD_A, CK_LOAD_B, CK_EXEC} t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [2:0]             op;
        logic [IDX_BITS-1:0]    idx;
        logic [WORD_BITS-1:0]   value;
    } t_cmd;

    typedef enum logic [1:0] {TK_DIRECT, TK_PROD2, TK_PROD3} t_term_kind;

    typedef struct packed {
        t_term_kind           kind;
        logic                 neg;
        logic [IDX_BITS-1:0]  xa;
        logic [IDX_BITS-1:0]  ya;
        logic                 yb;
        logic [IDX_BITS-1:0]  za;
        logic                 last;
    } t_term;

    function automatic logic [IDX_BITS-1:0] word_addr(input logic [1:0] r,
                                                      input logic [1:0] c,
                                                      input logic imag);
        return IDX_BITS'({r, 1'b0}) + IDX_BITS'(r) + IDX_BITS'(c)
             + (imag ? IDX_BITS'(NUM_WORDS / 2) : IDX_BITS'(0));
    endfunction

    function automatic logic word_last(input logic [2:0] op, input logic [IDX_BITS-1:0] w);
        return (op == OP_DET) ? (w == IDX_BITS'(1)) : (w == IDX_BITS'(NUM_WORDS - 1));
    endfunction

    // one product term of one result word
    function automatic t_term term_desc(input logic [2:0] op,
                                        input logic [IDX_BITS-1:0] w,
                                        input logic [IDX_BITS-1:0] t);
        t_term d;
        logic im;
        logic [3:0] e;
        logic [1:0] i, j, r1, r2, c1, c2, q, p0, p1, p2;
        logic [2:0] p;
        logic pn, fz;
        d  = '0;
        im = (w >= IDX_BITS'(NUM_WORDS / 2));
        e  = im ? 4'(w - IDX_BITS'(NUM_WORDS / 2)) : w[3:0];
        i  = (e >= 4'd6) ? 2'd2 : ((e >= 4'd3) ? 2'd1 : 2'd0);
        j  = 2'(e - (4'({i, 1'b0}) + 4'(i)));
        q  = t[1:0];
        p  = t[4:2];
        r1 = (j == 2'd0) ? 2'd1 : 2'd0;
        r2 = (j == 2'd2) ? 2'd1 : 2'd2;
        c1 = (i == 2'd0) ? 2'd1 : 2'd0;
        c2 = (i == 2'd2) ? 2'd1 : 2'd2;
        p0 = 2'd0; p1 = 2'd1; p2 = 2'd2; pn = 1'b0;
        case (p)
            3'd1:    begin p0 = 2'd0; p1 = 2'd2; p2 = 2'd1; pn = 1'b1; end
            3'd2:    begin p0 = 2'd1; p1 = 2'd0; p2 = 2'd2; pn = 1'b1; end
            3'd3:    begin p0 = 2'd1; p1 = 2'd2; p2 = 2'd0; pn = 1'b0; end
            3'd4:    begin p0 = 2'd2; p1 = 2'd0; p2 = 2'd1; pn = 1'b0; end
            3'd5:    begin p0 = 2'd2; p1 = 2'd1; p2 = 2'd0; pn = 1'b1; end
            default: begin p0 = 2'd0; p1 = 2'd1; p2 = 2'd2; pn = 1'b0; end
        endcase
        case (op)
            OP_MUL: begin
                d.kind = TK_PROD2;
                d.yb   = 1'b1;
                d.xa   = word_addr(i, t[2:1], t[0]);
                d.ya   = word_addr(t[2:1], j, im ? ~t[0] : t[0]);
                d.neg  = ~im & t[0];
                d.last = (t == IDX_BITS'(5));
            end
            OP_CONJ: begin
                d.kind = TK_DIRECT;
                d.xa   = word_addr(j, i, im);
                d.neg  = im;
                d.last = 1'b1;
            end
            OP_ADJ: begin
                d.kind = TK_PROD2;
                d.xa   = word_addr(r1, q[1] ? c2 : c1, q[0]);
                d.ya   = word_addr(r2, q[1] ? c1 : c2, im ? ~q[0] : q[0]);
                d.neg  = (im ? q[1] : (q[0] ^ q[1])) ^ i[0] ^ j[0];
                d.last = (t == IDX_BITS'(3));
            end
            OP_DET: begin
                // w[0] selects the imaginary part
                fz     = w[0] ? ~(q[0] ^ q[1]) : (q[0] ^ q[1]);
                d.kind = TK_PROD3;
                d.xa   = word_addr(2'd0, p0, q[1]);
                d.ya   = word_addr(2'd1, p1, q[0]);
                d.za   = word_addr(2'd2, p2, fz);
                d.neg  = (w[0] ? (q == 2'd3) : (q != 2'd0)) ^ pn;
                d.last = (t == IDX_BITS'(23));
            end
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

[sv/cmu_ram.sv]
// generic ram, one write port and two registered read ports
// no dependencies
module cmu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 18
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr0,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr1,
    output logic [WIDTH-1:0]           o_rdata0,
    output logic [WIDTH-1:0]           o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

[sv/cmu_front.sv]
// front end: accepts items, drops no-op items, queues commands
// depends on cmu_pkg
module cmu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cmu_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output cmu_pkg::t_cmd     o_cmd
);

    localparam int PW = $clog2(cmu_pkg::QDEPTH);

    cmu_pkg::t_cmd        r_q [cmu_pkg::QDEPTH];
    logic [PW-1:0]        r_wp, r_rp;
    logic [PW:0]          r_count;
    logic                 keep, push, pop;
    cmu_pkg::t_cmd        cmd;

    always_comb begin
        keep      = 1'b0;
        cmd.kind  = cmu_pkg::CK_EXEC;
        cmd.op    = i_item.opcode;
        cmd.idx   = i_item.word_index;
        cmd.value = cmu_pkg::WORD_BITS'(i_item.word_value);
        case (i_item.opcode) inside
            cmu_pkg::OP_LOAD_A: begin
                keep     = (i_item.word_index < 5'(cmu_pkg::NUM_WORDS));
                cmd.kind = cmu_pkg::CK_LOAD_A;
            end
            cmu_pkg::OP_LOAD_B: begin
                keep     = (i_item.word_index < 5'(cmu_pkg::NUM_WORDS));
                cmd.kind = cmu_pkg::CK_LOAD_B;
            end
            cmu_pkg::OP_MUL, cmu_pkg::OP_CONJ, cmu_pkg::OP_ADJ, cmu_pkg::OP_DET: begin
                keep = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_ready     = (r_count != (PW+1)'(cmu_pkg::QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready && keep;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd;
                r_wp      <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

[sv/cmu_back.sv]
// back end: term sequencer with shared multiplier, accumulator, saturation
// depends on cmu_pkg, cmu_ram and the macros header
`include "complex3x3_matrix_unit_macros.svh"

module cmu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  cmu_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output cmu_pkg::t_out_item o_item
);

    localparam int W  = cmu_pkg::WORD_BITS;
    localparam int AB = cmu_pkg::ACC_BITS;
    localparam int IB = cmu_pkg::IDX_BITS;
    localparam int AW = cmu_pkg::A_AW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ADDR, ST_MUL1, ST_ACC2, ST_TRUNC, ST_MULLO,
        ST_MULHI, ST_SUM, ST_ACC3, ST_DIRECT, ST_EMIT
    } t_state;

    t_state                              r_state;
    logic [2:0]                          r_op;
    logic [IB-1:0]                       r_word, r_term;
    logic signed [AB-1:0]                r_acc;
    logic signed [2*W-1:0]               r_mul, r_lo;
    logic signed [cmu_pkg::TRUNC_BITS-1:0] r_t;
    logic signed [W-1:0]                 r_z;
    logic signed [cmu_pkg::PROD3_BITS-1:0] r_s;
    logic                                r_bank;
    logic                                r_out_valid;
    cmu_pkg::t_out_item                  r_out;

    cmu_pkg::t_term        d;
    logic [W-1:0]          a0, a1, b0, b1_unused;
    logic signed [W-1:0]   mul_a, mul_b, y_data;
    logic signed [2*W-1:0] mul_p;
    logic signed [AB-1:0]  contrib, n_acc;
    logic [AB-W:0]         acc_hi;
    logic                  fits;
    logic [W-1:0]          sat_val;
    logic                  emit_go, w_last, bank_flip;
    logic                  a_we, b_we;
    logic [AW-1:0]         a_waddr, a_raddr0, a_raddr1;
    logic [W-1:0]          a_wdata;

    function automatic logic [AW-1:0] a_addr(input logic bank, input logic [IB-1:0] idx);
        return AW'(idx) + (bank ? AW'(cmu_pkg::NUM_WORDS) : AW'(0));
    endfunction

    always_comb begin
        d      = cmu_pkg::term_desc(r_op, r_word, r_term);
        y_data = d.yb ? b0 : a1;
        case (r_state)
            ST_MULLO: begin
                mul_a = W'({{(W-cmu_pkg::SPLIT_BITS){1'b0}}, r_t[cmu_pkg::SPLIT_BITS-1:0]});
                mul_b = r_z;
            end
            ST_MULHI: begin
                mul_a = W'(r_t >>> cmu_pkg::SPLIT_BITS);
                mul_b = r_z;
            end
            default: begin
                mul_a = a0;
                mul_b = y_data;
            end
        endcase
        mul_p = mul_a * mul_b;

        case (r_state)
            ST_DIRECT: contrib = AB'($signed(a0));
            ST_ACC3:   contrib = AB'(r_s >>> cmu_pkg::FRAC_BITS);
            default:   contrib = AB'(r_mul >>> cmu_pkg::FRAC_BITS);
        endcase
        n_acc = d.neg ? (r_acc - contrib) : (r_acc + contrib);

        acc_hi  = r_acc[AB-1:W-1];
        fits    = (&acc_hi) | ~(|acc_hi);
        sat_val = fits ? r_acc[W-1:0] : (r_acc[AB-1] ? {1'b1, {(W-1){1'b0}}}
                                                      : {1'b0, {(W-1){1'b1}}});

        emit_go   = (r_state == ST_EMIT) && (!r_out_valid || i_ready);
        w_last    = cmu_pkg::word_last(r_op, r_word);
        bank_flip = emit_go && w_last && (r_op != cmu_pkg::OP_DET);

        o_cmd_ready = (r_state == ST_IDLE);

        // loads write the live bank, results other than the determinant go to the other one
        a_we    = 1'b0;
        a_waddr = a_addr(r_bank, i_cmd.idx);
        a_wdata = i_cmd.value;
        if (r_state == ST_IDLE) begin
            a_we = i_cmd_valid && (i_cmd.kind == cmu_pkg::CK_LOAD_A);
        end else if (emit_go && (r_op != cmu_pkg::OP_DET)) begin
            a_we    = 1'b1;
            a_waddr = a_addr(~r_bank, r_word);
            a_wdata = sat_val;
        end
        b_we = (r_state == ST_IDLE) && i_cmd_valid && (i_cmd.kind == cmu_pkg::CK_LOAD_B);

        a_raddr0 = a_addr(r_bank, (r_state == ST_MUL1) ? d.za : d.xa);
        a_raddr1 = a_addr(r_bank, d.ya);
    end

    cmu_ram #(.WIDTH(W), .DEPTH(cmu_pkg::A_DEPTH)) u_ram_a (
        .i_clk    (i_clk),
        .i_we     (a_we),
        .i_waddr  (a_waddr),
        .i_wdata  (a_wdata),
        .i_raddr0 (a_raddr0),
        .i_raddr1 (a_raddr1),
        .o_rdata0 (a0),
        .o_rdata1 (a1)
    );

    cmu_ram #(.WIDTH(W), .DEPTH(cmu_pkg::NUM_WORDS)) u_ram_b (
        .i_clk    (i_clk),
        .i_we     (b_we),
        .i_waddr  (i_cmd.idx),
        .i_wdata  (i_cmd.value),
        .i_raddr0 (d.ya),
        .i_raddr1 (d.ya),
        .o_rdata0 (b0),
        .o_rdata1 (b1_unused)
    );

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= emit_go || (r_out_valid && !i_ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && (i_cmd.kind == cmu_pkg::CK_EXEC)) begin
                        r_op    <= i_cmd.op;
                        r_word  <= '0;
                        r_term  <= '0;
                        r_acc   <= '0;
                        r_state <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    r_state <= (d.kind == cmu_pkg::TK_DIRECT) ? ST_DIRECT : ST_MUL1;
                end
                ST_MUL1: begin
                    r_mul   <= mul_p;
                    r_state <= (d.kind == cmu_pkg::TK_PROD3) ? ST_TRUNC : ST_ACC2;
                end
                ST_TRUNC: begin
                    r_t     <= cmu_pkg::TRUNC_BITS'(r_mul >>> cmu_pkg::FRAC_BITS);
                    r_z     <= a0;
                    r_state <= ST_MULLO;
                end
                ST_MULLO: begin
                    r_lo    <= mul_p;
                    r_state <= ST_MULHI;
                end
                ST_MULHI: begin
                    r_mul   <= mul_p;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_s <= $signed({r_mul[cmu_pkg::PROD3_BITS-cmu_pkg::SPLIT_BITS-1:0],
                                    {cmu_pkg::SPLIT_BITS{1'b0}}})
                         + cmu_pkg::PROD3_BITS'(r_lo);
                    r_state <= ST_ACC3;
                end
                ST_ACC2, ST_ACC3, ST_DIRECT: begin
                    r_acc <= n_acc;
                    if (d.last) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_term  <= r_term + 1'b1;
                        r_state <= ST_ADDR;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_out.result_index  <= r_word;
                        r_out.result_value  <= 32'(sat_val);
                        r_out.last_word     <= w_last;
                        r_out.overflow      <= ~fits;
                        if (w_last) begin
                            if (bank_flip) begin
                                r_bank <= ~r_bank;
                            end
                            r_state <= ST_IDLE;
                        end else begin
                            r_word  <= r_word + 1'b1;
                            r_term  <= '0;
                            r_acc   <= '0;
                            r_state <= ST_ADDR;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `CMU_ASSERT_IMP(a_word_range, (r_state != ST_IDLE), (r_word < IB'(cmu_pkg::NUM_WORDS)), "word index past end")
    `CMU_ASSERT_NXT(a_bank_flip, bank_flip, (r_bank != $past(r_bank)), "bank did not flip")
    `CMU_ASSERT_IMP(a_acc3_kind, (r_state == ST_ACC3), (d.kind == cmu_pkg::TK_PROD3), "triple path on wrong term")

endmodule

[sv/complex3x3_matrix_unit.sv]
// 3x3 complex matrix unit: load, multiply, conjugate transpose, adjugate, determinant
// top level; depends on cmu_pkg, cmu_front, cmu_back (which holds the cmu_ram instances)
// a load is queued by the front end and written to the matrix store when the sequencer takes
//   it; an execute walks the terms of each result word through the one shared multiplier, and
//   the sequencer takes no new command until the last result word of that execute is out
// reset: synchronous active low, clears the queue, sequencer, output register and bank select
module complex3x3_matrix_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cmu_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output cmu_pkg::t_out_item o_item
);

    // command transaction between the front end queue and the sequencer
    logic          cmd_valid;
    logic          cmd_ready;
    cmu_pkg::t_cmd cmd;

    // front end: classifies each transaction, drops no-op items (unused opcodes and
    // out of range loads) and queues the rest so input keeps flowing while the
    // sequencer is busy
    cmu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // back end: matrix stores, term sequencer, shared 32x32 multiplier, wide
    // accumulator, saturation and the output register; results of multiply,
    // conjugate transpose and adjugate are written to the spare bank of A, which
    // becomes the live bank after the last word
    cmu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

[test/tb_top.sv]
// self-checking testbench for complex3x3_matrix_unit: predicts every result word of
// load, multiply, conjugate-transpose, adjugate and determinant transactions
// depends on cmu_pkg and the complex3x3_matrix_unit rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // predicts the result words of each accepted transaction and checks them in order
    class matrix_results;
        logic [31:0]        mat_a [18];
        logic [31:0]        mat_b [18];
        cmu_pkg::t_out_item pending_words [$];
        int                 errors;
        int                 words_seen;

        function new();
            errors = 0;
            words_seen = 0;
            foreach (mat_a[k]) begin
                mat_a[k] = '0;
                mat_b[k] = '0;
            end
        endfunction

        function logic signed [127:0] wx(logic [31:0] w);
            logic signed [127:0] r;
            r = $signed(w);
            return r;
        endfunction

        // exact product, then arithmetic shift by the fraction width
        function logic signed [127:0] mul2(logic [31:0] x, logic [31:0] y);
            logic signed [127:0] p;
            p = wx(x) * wx(y);
            return p >>> cmu_pkg::FRAC_BITS;
        endfunction

        function logic signed [127:0] mul3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
            logic signed [127:0] p;
            p = mul2(x, y) * wx(z);
            return p >>> cmu_pkg::FRAC_BITS;
        endfunction

        function logic [31:0] are(int i, int j);
            return mat_a[3 * i + j];
        endfunction

        function logic [31:0] aim(int i, int j);
            return mat_a[9 + 3 * i + j];
        endfunction

        // clamp to the word range and queue the expected word
        function logic [31:0] push_word(int idx, logic signed [127:0] v, bit last);
            cmu_pkg::t_out_item w;
            logic signed [127:0] hi, lo;
            hi = 128'sd2147483647;
            lo = -128'sd2147483648;
            w.result_index = 5'(idx);
            w.last_word = last;
            w.overflow = 1'b0;
            if (v > hi) begin
                w.result_value = 32'h7fff_ffff;
                w.overflow = 1'b1;
            end else if (v < lo) begin
                w.result_value = 32'h8000_0000;
                w.overflow = 1'b1;
            end else begin
                w.result_value = v[31:0];
            end
            pending_words.push_back(w);
            return w.result_value;
        endfunction

        function void take_transaction(cmu_pkg::t_in_item it);
            logic signed [127:0] res [18];
            logic signed [127:0] re, im, tr, ti;
            logic [31:0] xr, xi, yr, yi, zr, zi, ur, ui, vr, vi;
            int perm [6][3];
            bit perm_odd [6];
            int r1, r2, c1, c2;
            logic [31:0] dummy;
            perm = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2}, '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};
            perm_odd = '{0, 1, 1, 0, 0, 1};
            case (it.opcode)
                cmu_pkg::OP_LOAD_A:
                    if (it.word_index < cmu_pkg::NUM_WORDS) mat_a[it.word_index] = it.word_value;
                cmu_pkg::OP_LOAD_B:
                    if (it.word_index < cmu_pkg::NUM_WORDS) mat_b[it.word_index] = it.word_value;
                cmu_pkg::OP_DET: begin
                    re = 0;
                    im = 0;
                    for (int k = 0; k < 6; k++) begin
                        xr = are(0, perm[k][0]); xi = aim(0, perm[k][0]);
                        yr = are(1, perm[k][1]); yi = aim(1, perm[k][1]);
                        zr = are(2, perm[k][2]); zi = aim(2, perm[k][2]);
                        tr = mul3(xr, yr, zr) - mul3(xr, yi, zi) - mul3(xi, yr, zi)
                           - mul3(xi, yi, zr);
                        ti = mul3(xr, yr, zi) + mul3(xr, yi, zr) + mul3(xi, yr, zr)
                           - mul3(xi, yi, zi);
                        if (perm_odd[k]) begin
                            re = re - tr;
                            im = im - ti;
                        end else begin
                            re = re + tr;
                            im = im + ti;
                        end
                    end
                    dummy = push_word(0, re, 1'b0);
                    dummy = push_word(1, im, 1'b1);
                end
                cmu_pkg::OP_MUL, cmu_pkg::OP_CONJ, cmu_pkg::OP_ADJ: begin
                    for (int i = 0; i < 3; i++) begin
                        for (int j = 0; j < 3; j++) begin
                            if (it.opcode == cmu_pkg::OP_MUL) begin
                                re = 0;
                                im = 0;
                                for (int k = 0; k < 3; k++) begin
                                    xr = are(i, k); xi = aim(i, k);
                                    yr = mat_b[3 * k + j]; yi = mat_b[9 + 3 * k + j];
                                    re = re + mul2(xr, yr) - mul2(xi, yi);
                                    im = im + mul2(xr, yi) + mul2(xi, yr);
                                end
                            end else if (it.opcode == cmu_pkg::OP_CONJ) begin
                                re = wx(are(j, i));
                                im = -wx(aim(j, i));
                            end else begin
                                // signed minor of entry (j,i)
                                r1 = (j == 0) ? 1 : 0; r2 = (j == 2) ? 1 : 2;
                                c1 = (i == 0) ? 1 : 0; c2 = (i == 2) ? 1 : 2;
                                xr = are(r1, c1); xi = aim(r1, c1);
                                yr = are(r2, c2); yi = aim(r2, c2);
                                ur = are(r1, c2); ui = aim(r1, c2);
                                vr = are(r2, c1); vi = aim(r2, c1);
                                re = (mul2(xr, yr) - mul2(xi, yi)) - (mul2(ur, vr) - mul2(ui, vi));
                                im = (mul2(xr, yi) + mul2(xi, yr)) - (mul2(ur, vi) + mul2(ui, vr));
                                if ((i + j) % 2 == 1) begin
                                    re = -re;
                                    im = -im;
                                end
                            end
                            res[3 * i + j] = re;
                            res[9 + 3 * i + j] = im;
                        end
                    end
                    // results replace matrix a so operations chain
                    for (int k = 0; k < 18; k++) mat_a[k] = push_word(k, res[k], k == 17);
                end
                default: ;
            endcase
        endfunction

        function void check_word(cmu_pkg::t_out_item got);
            cmu_pkg::t_out_item want;
            words_seen++;
            if (pending_words.size() == 0) begin
                errors++;
                $error("result word with none pending: index %0d value %h",
                       got.result_index, got.result_value);
                return;
            end
            want = pending_words.pop_front();
            if (got.result_index !== want.result_index) begin
                errors++;
                $error("result_index: expected %0d, got %0d", want.result_index, got.result_index);
            end
            if (got.result_value !== want.result_value) begin
                errors++;
                $error("result_value: expected %h, got %h", want.result_value, got.result_value);
            end
            if (got.last_word !== want.last_word) begin
                errors++;
                $error("last_word: expected %b, got %b", want.last_word, got.last_word);
            end
            if (got.overflow !== want.overflow) begin
                errors++;
                $error("overflow: expected %b, got %b", want.overflow, got.overflow);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    cmu_pkg::t_in_item  i_item;
    logic               o_valid;
    logic               i_ready;
    cmu_pkg::t_out_item o_item;

    matrix_results results;
    int        op_count [8];
    int        sent;
    int        quiet_cycles;
    bit        no_gaps;

    localparam int QUIET_LIMIT = 4000;

    complex3x3_matrix_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // mostly small magnitudes so chained results stay in range, plus the extremes
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0100_0000;
            3, 4:    return $urandom;
            default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        endcase
    endfunction

    // one input transaction; entered and left at a falling edge
    task automatic send_item(logic [2:0] op, logic [4:0] idx, logic [31:0] val);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= '{opcode: op, word_index: idx, word_value: val};
        do @(posedge i_clk); while (!o_ready);
        results.take_transaction(i_item);
        op_count[op]++;
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_exec(logic [2:0] op);
        send_item(op, 5'($urandom), $urandom);
    endtask

    // hold the sender until every pending word has come back
    task automatic drain();
        i_valid <= 1'b0;
        while (results.pending_words.size() != 0) @(negedge i_clk);
    endtask

    task automatic load_matrix(logic [2:0] op);
        for (int k = 0; k < cmu_pkg::NUM_WORDS; k++) send_item(op, 5'(k), pick_value());
    endtask

    // receiver: random stall before each result transaction
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) results.check_word(o_item);
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("complex3x3_matrix_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int r;
        int n;
        results = new();
        foreach (op_count[k]) op_count[k] = 0;
        sent = 0;
        quiet_cycles = 0;
        no_gaps = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: both matrices fully written before any execute reads them
        load_matrix(cmu_pkg::OP_LOAD_A);
        load_matrix(cmu_pkg::OP_LOAD_B);
        send_item(cmu_pkg::OP_LOAD_A, 5'd31, 32'hdead_beef);  // out-of-range load, ignored
        send_item(cmu_pkg::OP_LOAD_B, 5'd18, 32'h1234_5678);
        send_exec(cmu_pkg::OP_MUL);
        send_exec(cmu_pkg::OP_DET);
        send_exec(3'd6);                              // unused codes do nothing
        send_exec(3'd7);
        // most negative word negated by conjugate transpose saturates
        send_item(cmu_pkg::OP_LOAD_A, 5'd9, 32'h8000_0000);
        send_item(cmu_pkg::OP_LOAD_A, 5'd0, 32'h7fff_ffff);
        send_exec(cmu_pkg::OP_CONJ);
        send_exec(cmu_pkg::OP_ADJ);
        send_exec(cmu_pkg::OP_DET);
        drain();

        // random: short load bursts followed by an execute, plus noise
        while (sent < 470) begin
            no_gaps = (sent >= 250 && sent < 300);
            r = $urandom_range(0, 19);
            if (r == 0) begin
                load_matrix(cmu_pkg::OP_LOAD_A);
            end else if (r == 1) begin
                send_item(3'($urandom_range(0, 1)), 5'($urandom_range(18, 31)), $urandom);
            end else if (r == 2) begin
                send_exec(3'($urandom_range(6, 7)));
            end else begin
                n = $urandom_range(0, 5);
                repeat (n) begin
                    send_item(3'($urandom_range(0, 1)), 5'($urandom_range(0, 17)), pick_value());
                end
                send_exec(3'($urandom_range(2, 5)));
            end
        end
        no_gaps = 1'b0;
        i_valid <= 1'b0;

        while (results.pending_words.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("covered %0d transactions: %0d loads, %0d multiply, %0d conjugate, %0d adjugate,",
                 sent, op_count[0] + op_count[1], op_count[2], op_count[3], op_count[4]);
        $display("  %0d determinant, %0d unused; %0d result words checked, %0d errors",
                 op_count[5], op_count[6] + op_count[7], results.words_seen, results.errors);
        if (results.errors == 0 && results.pending_words.size() == 0) begin
            $display("complex3x3_matrix_unit: match");
        end else begin
            $display("complex3x3_matrix_unit: mismatch");
        end
        $finish;
    end
endmodule
